// ===== src/flq_pkg.sv =====
// ----------------------------------------------------------------------------
// flq_pkg: shared types and codes of the fifo lock
// beat layouts of both channels, command and status codes
// ----------------------------------------------------------------------------
package flq_pkg;

    // width of the task fields on the ports
    localparam int TASK_W = 16;

    // command codes (code three is unused)
    localparam logic [1:0] CMD_ENTER  = 2'd0;
    localparam logic [1:0] CMD_LEAVE  = 2'd1;
    localparam logic [1:0] CMD_EXIT   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_HANDOFF  = 3'd3;
    localparam logic [2:0] ST_FREED    = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;

    typedef struct packed {
        logic [1:0]        command;
        logic [TASK_W-1:0] task_id;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic              wake_valid;
        logic [TASK_W-1:0] wake_task;
        logic [TASK_W-1:0] owner_now;
    } t_out;

endpackage

// ===== src/flq_ram.sv =====
// ----------------------------------------------------------------------------
// flq_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module flq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fifo_lock_with_wait_queue.sv =====
// ----------------------------------------------------------------------------
// fifo_lock_with_wait_queue: single owner lock with a fifo of waiting tasks
// enter takes or queues, leave hands off to the oldest waiter, exit aborts
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one command beat (t_in),
//   a beat is taken when both are high. output channel: o_out_valid /
//   i_out_ready carry exactly one result beat (t_out) per command.
//   steps: enter, a leave or exit with an empty queue, and unused commands
//   go from the accept straight to the result state (S_DONE). a handoff
//   reads the head entry (S_HEAD), then moves every remaining waiter up one
//   slot (S_SHIFT_RD, S_SHIFT_WR); an exit scans the queue from the oldest
//   entry (S_SCAN) and closes the gap behind a hit the same way. the time is
//   set by the single read port of the queue ram: every compare and every
//   entry move goes through it, one entry per read.
//   the block takes one command at a time; o_in_ready is high only when no
//   command is in work. a finished result sits in the output register, so
//   the next command is taken while the receiver stalls; a second result
//   waits inside until the output register frees up.
//   reset (synchronous, active low) frees the lock and empties the queue.
//   the queue ram itself is not cleared: only written entries are read.
// ----------------------------------------------------------------------------
module fifo_lock_with_wait_queue #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  flq_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output flq_pkg::t_out o_out
);

    // stored id width: ids are masked to TASK_ID_BITS, ports carry 16 bits
    localparam int IW = (TASK_ID_BITS < flq_pkg::TASK_W) ? TASK_ID_BITS : flq_pkg::TASK_W;
    // ram address and queue count widths
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_HEAD     = 7'b0000010,   // head entry on the read port
        S_SCAN     = 7'b0000100,   // compare one queue entry with the task
        S_SHIFT_RD = 7'b0001000,   // fetch the entry behind the gap
        S_SHIFT_WR = 7'b0010000,   // move it up into the gap
        S_DONE     = 7'b0100000,   // result ready, wait for the output slot
        S_SPARE    = 7'b1000000    // never entered
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_owner, n_owner;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [IW-1:0]    r_id, n_id;
    logic [2:0]       r_status, n_status;
    logic             r_wake_valid, n_wake_valid;
    logic [IW-1:0]    r_wake_task, n_wake_task;
    logic             r_out_valid, n_out_valid;
    flq_pkg::t_out    r_out, n_out;

    // queue ram port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [IW-1:0]    ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [IW-1:0]    ram_rdata;

    logic [IW-1:0]    in_id;
    logic [CW-1:0]    ptr_inc;
    logic             do_release;

    assign in_id   = i_in.task_id[IW-1:0];
    assign ptr_inc = r_ptr + CW'(1);

    flq_ram #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_owner      = r_owner;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_id         = r_id;
        n_status     = r_status;
        n_wake_valid = r_wake_valid;
        n_wake_task  = r_wake_task;
        n_out        = r_out;
        // output beat leaves when taken
        n_out_valid  = r_out_valid && !i_out_ready;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        do_release   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_id         = in_id;
                    n_wake_valid = 1'b0;
                    n_wake_task  = '0;
                    n_state      = S_DONE;
                    unique case (i_in.command)
                        flq_pkg::CMD_ENTER: begin
                            if (r_owner == '0) begin
                                n_owner  = in_id;
                                n_status = flq_pkg::ST_GRANTED;
                            end else if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_status = flq_pkg::ST_FULL;
                            end else begin
                                // append at the tail
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = in_id;
                                n_count   = r_count + CW'(1);
                                n_status  = flq_pkg::ST_QUEUED;
                            end
                        end
                        flq_pkg::CMD_LEAVE: begin
                            do_release = 1'b1;
                        end
                        flq_pkg::CMD_EXIT: begin
                            if (r_owner == in_id) begin
                                do_release = 1'b1;
                            end else if (r_count == '0) begin
                                n_status = flq_pkg::ST_NOTFOUND;
                            end else begin
                                // start the scan at the oldest waiter
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_ptr     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = flq_pkg::ST_NOTFOUND;
                        end
                    endcase
                    if (do_release) begin
                        n_owner = '0;
                        if (r_count == '0) begin
                            n_status = flq_pkg::ST_FREED;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_state   = S_HEAD;
                        end
                    end
                end
            end
            S_HEAD: begin
                // oldest waiter takes the lock, the rest moves up from slot zero
                n_owner      = ram_rdata;
                n_wake_valid = 1'b1;
                n_wake_task  = ram_rdata;
                n_status     = flq_pkg::ST_HANDOFF;
                n_ptr        = '0;
                n_state      = S_SHIFT_RD;
            end
            S_SCAN: begin
                if (ram_rdata == r_id) begin
                    n_status = flq_pkg::ST_REMOVED;
                    n_state  = S_SHIFT_RD;
                end else if (ptr_inc >= r_count) begin
                    n_status = flq_pkg::ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_inc[AW-1:0];
                    n_ptr     = ptr_inc;
                end
            end
            S_SHIFT_RD: begin
                if (ptr_inc < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_inc[AW-1:0];
                    n_state   = S_SHIFT_WR;
                end else begin
                    // gap has reached the tail
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = ram_rdata;
                n_ptr     = ptr_inc;
                n_state   = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status     = r_status;
                    n_out.wake_valid = r_wake_valid;
                    n_out.wake_task  = flq_pkg::TASK_W'(r_wake_task);
                    n_out.owner_now  = flq_pkg::TASK_W'(r_owner);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_owner     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_owner     <= n_owner;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // work registers and output payload
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_id         <= n_id;
        r_status     <= n_status;
        r_wake_valid <= n_wake_valid;
        r_wake_task  <= n_wake_task;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("wait count beyond queue depth");

    // an entry move always follows its fetch
    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_WR) |-> ($past(r_state) == S_SHIFT_RD))
        else $error("entry move without fetch");

    // a handoff result names the new owner as the woken task
    a_handoff_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == flq_pkg::ST_HANDOFF))
        |-> (o_out.wake_valid && (o_out.wake_task == o_out.owner_now)))
        else $error("handoff beat inconsistent");

    // enter on a free lock grants it at once
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.command == flq_pkg::CMD_ENTER)
         && (r_owner == '0)) |=> (r_owner == $past(in_id)))
        else $error("free lock not granted");

endmodule

// ===== tb/flq_lock_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flq_lock_monitor: watches both channels of the fifo lock and checks results
// keeps its own copy of owner and wait queue, works out the result of every
// accepted command beat and compares each result beat with the oldest one due
// ----------------------------------------------------------------------------
module flq_lock_monitor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  flq_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  flq_pkg::t_out i_out,
    output int            o_fails,
    output int            o_pending
);

    localparam int DEPTH = 16;

    logic [flq_pkg::TASK_W-1:0] lock_owner;
    logic [flq_pkg::TASK_W-1:0] waiters [DEPTH];
    int                         waiter_cnt;
    int                         fails;
    flq_pkg::t_out              due_results [$];

    // free the lock, hand it to the head of the queue if anyone waits
    task automatic release_lock(inout flq_pkg::t_out res);
        lock_owner = '0;
        if (waiter_cnt == 0) begin
            res.status = flq_pkg::ST_FREED;
        end else begin
            res.wake_valid = 1'b1;
            res.wake_task  = waiters[0];
            for (int k = 0; k + 1 < waiter_cnt; k++) waiters[k] = waiters[k + 1];
            waiter_cnt--;
            lock_owner = res.wake_task;
            res.status = flq_pkg::ST_HANDOFF;
        end
    endtask

    // take the oldest entry of id out of the queue and close the gap
    task automatic drop_waiter(input logic [flq_pkg::TASK_W-1:0] id,
                               inout flq_pkg::t_out res);
        int hit;
        hit = -1;
        res.status = flq_pkg::ST_NOTFOUND;
        for (int k = 0; k < waiter_cnt; k++) begin
            if (hit < 0 && waiters[k] == id) hit = k;
        end
        if (hit >= 0) begin
            for (int m = hit; m + 1 < waiter_cnt; m++) waiters[m] = waiters[m + 1];
            waiter_cnt--;
            res.status = flq_pkg::ST_REMOVED;
        end
    endtask

    task automatic grant_outcome(input flq_pkg::t_in beat, output flq_pkg::t_out res);
        res = '0;
        res.status = flq_pkg::ST_NOTFOUND;
        case (beat.command)
            flq_pkg::CMD_ENTER: begin
                if (lock_owner == '0) begin
                    lock_owner = beat.task_id;
                    res.status = flq_pkg::ST_GRANTED;
                end else if (waiter_cnt >= DEPTH) begin
                    res.status = flq_pkg::ST_FULL;
                end else begin
                    waiters[waiter_cnt] = beat.task_id;
                    waiter_cnt++;
                    res.status = flq_pkg::ST_QUEUED;
                end
            end
            flq_pkg::CMD_LEAVE: begin
                release_lock(res);
            end
            flq_pkg::CMD_EXIT: begin
                if (lock_owner == beat.task_id) release_lock(res);
                else drop_waiter(beat.task_id, res);
            end
            default: ;
        endcase
        res.owner_now = lock_owner;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        flq_pkg::t_out want;
        if (!i_rst_n) begin
            lock_owner = '0;
            waiter_cnt = 0;
            for (int k = 0; k < DEPTH; k++) waiters[k] = '0;
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                grant_outcome(i_in, want);
                due_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing due: %p", i_out);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out.status));
                    check_field("wake_valid", 32'(want.wake_valid), 32'(i_out.wake_valid));
                    check_field("wake_task", 32'(want.wake_task), 32'(i_out.wake_task));
                    check_field("owner_now", 32'(want.owner_now), 32'(i_out.owner_now));
                end
            end
        end
        o_fails   <= fails;
        o_pending <= due_results.size();
    end

    initial begin
        fails      = 0;
        waiter_cnt = 0;
        lock_owner = '0;
    end

endmodule

// ===== tb/tb_fifo_lock_with_wait_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_lock_with_wait_queue: stimulus and verdict for the fifo lock
// a directed run over the corner cases, then random command sequences with
// random gaps on both channels; the lock monitor does all result checking
// ----------------------------------------------------------------------------
module tb_fifo_lock_with_wait_queue;

    localparam int N_ITEMS    = 950;   // rough size of the random part
    localparam int IDLE_LIMIT = 4000;  // cycles without any beat before giving up
    localparam int HOLD_LEN   = 400;   // long receiver hold-off
    localparam int HOLD_AT_A  = 1500;  // receiver cycles at which a hold-off starts
    localparam int HOLD_AT_B  = 8000;
    localparam int TAIL       = 100;   // settle time after the last result

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_ready = 1'b0;
    flq_pkg::t_in  i_in        = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    flq_pkg::t_out o_out;

    int fails;
    int pending;
    int sent_cnt = 0;
    int idle_cnt = 0;
    bit tx_steady = 1'b0;

    // ids the random sequences draw from, so exits and duplicates hit
    logic [flq_pkg::TASK_W-1:0] id_pool [8];

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    fifo_lock_with_wait_queue #(
        .QUEUE_DEPTH  (16),
        .TASK_ID_BITS (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    flq_lock_monitor u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    // gap length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // offer one command beat and hold it until it is taken
    task automatic send_beat(input logic [1:0] cmd,
                             input logic [flq_pkg::TASK_W-1:0] id);
        flq_pkg::t_in beat;
        int           gap;
        beat.command = cmd;
        beat.task_id = id;
        i_in       <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sent_cnt++;
        // with no gap valid simply stays high for the next beat
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // watchdog: a hang shows up as a long run of cycles without any beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cnt <= 0;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random stalls, calm stretches, and two long hold-offs that
    // back the block up while the sender keeps offering commands
    initial begin : receiver
        int  stall;
        int  cyc;
        bit  steady;
        stall  = 0;
        cyc    = 0;
        steady = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 256 == 0) steady = ($urandom_range(0, 3) == 0);
            if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) stall = HOLD_LEN;
            if (stall == 0 && !steady && $urandom_range(0, 99) < 30) stall = gap_len();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int kind;
        int r;
        int seg_len;
        logic [1:0]                 cmd;
        logic [flq_pkg::TASK_W-1:0] id;

        // reset held at the start only, never again
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        send_beat(flq_pkg::CMD_LEAVE, 16'h0005);   // leave of a lock that is already free
        send_beat(flq_pkg::CMD_EXIT, 16'h0001);    // exit of a task nobody knows
        send_beat(flq_pkg::CMD_UNUSED, 16'hA5A5);  // unused command code
        send_beat(flq_pkg::CMD_ENTER, 16'h0000);   // grant to task zero keeps the lock free
        send_beat(flq_pkg::CMD_EXIT, 16'h0000);    // task zero exits a free lock
        send_beat(flq_pkg::CMD_ENTER, 16'hFFFF);   // grant
        // fill the queue: one-hot ids, the owner itself, and a duplicate
        for (int k = 0; k < 14; k++) send_beat(flq_pkg::CMD_ENTER, 16'(1 << k));
        send_beat(flq_pkg::CMD_ENTER, 16'hFFFF);   // owner queues behind others
        send_beat(flq_pkg::CMD_ENTER, 16'h0001);   // same task waits twice
        send_beat(flq_pkg::CMD_ENTER, 16'h7FFF);   // queue full, nothing changes
        send_beat(flq_pkg::CMD_EXIT, 16'h0001);    // only the oldest entry goes
        send_beat(flq_pkg::CMD_EXIT, 16'hFFFF);    // owner aborts: handoff
        send_beat(flq_pkg::CMD_LEAVE, 16'h1234);   // leave from a task that does not own it
        send_beat(flq_pkg::CMD_EXIT, 16'h8000);    // id never entered

        // ---- random part: sequences over a small id pool ----
        sent_cnt = 0;
        while (sent_cnt < N_ITEMS) begin
            kind      = $urandom_range(0, 9);
            seg_len   = $urandom_range(8, 40);
            tx_steady = ($urandom_range(0, 3) == 0);
            for (int p = 0; p < 8; p++) id_pool[p] = 16'($urandom_range(1, 65535));
            // a burst of enters pushes the queue up, often to full
            if (kind < 2) begin
                repeat ($urandom_range(12, 20)) begin
                    send_beat(flq_pkg::CMD_ENTER, id_pool[$urandom_range(0, 7)]);
                end
            end
            repeat (seg_len) begin
                if (kind == 9) begin
                    // noise: any command, any id, now and then the odd ones
                    cmd = 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 19) == 0) cmd = flq_pkg::CMD_UNUSED;
                    id = 16'($urandom_range(1, 65535));
                    if ($urandom_range(0, 19) == 0) id = '0;
                end else begin
                    r  = $urandom_range(0, 99);
                    id = id_pool[$urandom_range(0, 7)];
                    if (r < 45) begin
                        cmd = flq_pkg::CMD_ENTER;
                    end else if (r < 70) begin
                        cmd = flq_pkg::CMD_LEAVE;
                    end else begin
                        cmd = flq_pkg::CMD_EXIT;
                        if ($urandom_range(0, 9) == 0) id = 16'($urandom_range(1, 65535));
                    end
                end
                send_beat(cmd, id);
            end
        end
        tx_steady = 1'b0;
        i_in_valid <= 1'b0;

        // one edge so the pending count covers the last beat, then drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
